// ===== design/lca_pkg.sv =====
// Shared types and constants for the lowest common ancestor engine.
// Holds the request and response words, memory write enables and sequencer status.
// No dependencies.
package lca_pkg;

	localparam int VTX_W         = 10;
	localparam int MAX_NODES_DEF = 1024;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic {
		RSP_BUILD  = 1'b0,
		RSP_ANSWER = 1'b1
	} kind_t;

	typedef struct packed {
		cmd_t             command;
		logic [VTX_W-1:0] vertex_a;
		logic [VTX_W-1:0] vertex_b;
		logic             last_entry;
	} req_t;

	typedef struct packed {
		kind_t            response_kind;
		logic [VTX_W-1:0] ancestor;
		logic             error;
	} rsp_t;

	typedef struct packed {
		logic order;
		logic head;
	} pm_we_t;

	typedef struct packed {
		logic parent;
		logic pre;
		logic inl;
		logic asc;
	} vm_we_t;

	typedef struct packed {
		logic idle;
		logic res_valid;
	} seq_st_t;

endpackage

// ===== design/tree_lowest_common_ancestor.sv =====
// Lowest common ancestor engine over a tree loaded in preorder (Schieber-Vishkin).
// A load word does not block the input unless it is marked last. The word marked last
// starts the build, and the input stays stalled until the build result has moved to
// the output register. The build is a copy pass, an upward pass over each non-root
// vertex, a root step and a downward pass over each non-root vertex. The single read
// port of each table memory serializes these steps. A query walks a chain of
// dependent registered memory reads, and the next word can enter once its result has
// moved to the output register. A query that is rejected with the error flag goes
// straight to its answer and blocks the input until that answer has moved on.
// One word is worked on at a time. The result register lets the next word enter
// while the previous result waits on rsp_stall.
// Depends on lca_pkg, lca_seq, lca_pmem and lca_vmem.
module tree_lowest_common_ancestor import lca_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);

	seq_st_t          st;
	rsp_t             res;
	logic             out_free;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic [AW-1:0]    pm_raddr, pm_waddr;
	logic [VTX_W-1:0] pm_rd_order, pm_rd_head, pm_wdata;
	pm_we_t           pm_we;
	logic [AW-1:0]    vm_raddr, vm_waddr;
	logic [VTX_W-1:0] vm_rd_parent, vm_wd_parent;
	logic [CW-1:0]    vm_rd_pre, vm_rd_inl, vm_rd_asc;
	logic [CW-1:0]    vm_wd_pre, vm_wd_inl, vm_wd_asc;
	vm_we_t           vm_we;

	lca_seq #(.MAX_NODES(MAX_NODES)) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req),
		.out_free     (out_free),
		.st           (st),
		.res          (res),
		.pm_raddr     (pm_raddr),
		.pm_rd_order  (pm_rd_order),
		.pm_rd_head   (pm_rd_head),
		.pm_we        (pm_we),
		.pm_waddr     (pm_waddr),
		.pm_wdata     (pm_wdata),
		.vm_raddr     (vm_raddr),
		.vm_rd_parent (vm_rd_parent),
		.vm_rd_pre    (vm_rd_pre),
		.vm_rd_inl    (vm_rd_inl),
		.vm_rd_asc    (vm_rd_asc),
		.vm_we        (vm_we),
		.vm_waddr     (vm_waddr),
		.vm_wd_parent (vm_wd_parent),
		.vm_wd_pre    (vm_wd_pre),
		.vm_wd_inl    (vm_wd_inl),
		.vm_wd_asc    (vm_wd_asc)
	);

	lca_pmem #(.MAX_NODES(MAX_NODES)) u_pmem (
		.clk      (clk),
		.raddr    (pm_raddr),
		.rd_order (pm_rd_order),
		.rd_head  (pm_rd_head),
		.we       (pm_we),
		.waddr    (pm_waddr),
		.wdata    (pm_wdata)
	);

	lca_vmem #(.MAX_NODES(MAX_NODES)) u_vmem (
		.clk       (clk),
		.raddr     (vm_raddr),
		.rd_parent (vm_rd_parent),
		.rd_pre    (vm_rd_pre),
		.rd_inl    (vm_rd_inl),
		.rd_asc    (vm_rd_asc),
		.we        (vm_we),
		.waddr     (vm_waddr),
		.wd_parent (vm_wd_parent),
		.wd_pre    (vm_wd_pre),
		.wd_inl    (vm_wd_inl),
		.wd_asc    (vm_wd_asc)
	);

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= st.res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && st.res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_query_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && req.command == CMD_QUERY) |=> req_stall)
		else $error("query word did not block the input");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		!st.idle |-> req_stall)
		else $error("input open while the sequencer is busy");

	a_error_form: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.error) |-> (rsp.ancestor == '0 && rsp.response_kind == RSP_ANSWER))
		else $error("error word carries an ancestor or build kind");

	a_result_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(st.res_valid && out_free) |=> (rsp_valid && rsp == $past(res)))
		else $error("result word lost on its way to the output register");
`endif

endmodule

// ===== design/lca_pmem.sv =====
// Position-indexed memory: preorder vertex list and head table.
// One write and one registered read per cycle. Depends on lca_pkg.
module lca_pmem import lca_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF,
	localparam int AW = $clog2(MAX_NODES)
) (
	input  logic             clk,
	input  logic [AW-1:0]    raddr,
	output logic [VTX_W-1:0] rd_order,
	output logic [VTX_W-1:0] rd_head,
	input  pm_we_t           we,
	input  logic [AW-1:0]    waddr,
	input  logic [VTX_W-1:0] wdata
);

	logic [VTX_W-1:0] order_mem [MAX_NODES];
	logic [VTX_W-1:0] head_mem  [MAX_NODES];
	logic [VTX_W-1:0] rd_order_q;
	logic [VTX_W-1:0] rd_head_q;

	always_ff @(posedge clk) begin
		if (we.order) begin
			order_mem[waddr] <= wdata;
		end
		if (we.head) begin
			head_mem[waddr] <= wdata;
		end
		rd_order_q <= order_mem[raddr];
		rd_head_q  <= head_mem[raddr];
	end

	assign rd_order = rd_order_q;
	assign rd_head  = rd_head_q;

endmodule

// ===== design/lca_vmem.sv =====
// Vertex-indexed memory: parent, preorder index, inlabel and ascendant mask.
// Per-field write enables, one registered read per cycle. Depends on lca_pkg.
module lca_vmem import lca_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF,
	localparam int AW = $clog2(MAX_NODES),
	localparam int CW = $clog2(MAX_NODES + 1)
) (
	input  logic             clk,
	input  logic [AW-1:0]    raddr,
	output logic [VTX_W-1:0] rd_parent,
	output logic [CW-1:0]    rd_pre,
	output logic [CW-1:0]    rd_inl,
	output logic [CW-1:0]    rd_asc,
	input  vm_we_t           we,
	input  logic [AW-1:0]    waddr,
	input  logic [VTX_W-1:0] wd_parent,
	input  logic [CW-1:0]    wd_pre,
	input  logic [CW-1:0]    wd_inl,
	input  logic [CW-1:0]    wd_asc
);

	logic [VTX_W-1:0] parent_mem [MAX_NODES];
	logic [CW-1:0]    pre_mem    [MAX_NODES];
	logic [CW-1:0]    inl_mem    [MAX_NODES];
	logic [CW-1:0]    asc_mem    [MAX_NODES];
	logic [VTX_W-1:0] rd_parent_q;
	logic [CW-1:0]    rd_pre_q;
	logic [CW-1:0]    rd_inl_q;
	logic [CW-1:0]    rd_asc_q;

	always_ff @(posedge clk) begin
		if (we.parent) begin
			parent_mem[waddr] <= wd_parent;
		end
		if (we.pre) begin
			pre_mem[waddr] <= wd_pre;
		end
		if (we.inl) begin
			inl_mem[waddr] <= wd_inl;
		end
		if (we.asc) begin
			asc_mem[waddr] <= wd_asc;
		end
		rd_parent_q <= parent_mem[raddr];
		rd_pre_q    <= pre_mem[raddr];
		rd_inl_q    <= inl_mem[raddr];
		rd_asc_q    <= asc_mem[raddr];
	end

	assign rd_parent = rd_parent_q;
	assign rd_pre    = rd_pre_q;
	assign rd_inl    = rd_inl_q;
	assign rd_asc    = rd_asc_q;

endmodule

// ===== design/lca_seq.sv =====
// Sequencer: load, three-pass table build and query walk over both memories.
// Accesses are serialized so no read overlaps a pending write. Depends on lca_pkg.
module lca_seq import lca_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF,
	localparam int AW = $clog2(MAX_NODES),
	localparam int CW = $clog2(MAX_NODES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	input  logic             out_free,
	output seq_st_t          st,
	output rsp_t             res,
	output logic [AW-1:0]    pm_raddr,
	input  logic [VTX_W-1:0] pm_rd_order,
	input  logic [VTX_W-1:0] pm_rd_head,
	output pm_we_t           pm_we,
	output logic [AW-1:0]    pm_waddr,
	output logic [VTX_W-1:0] pm_wdata,
	output logic [AW-1:0]    vm_raddr,
	input  logic [VTX_W-1:0] vm_rd_parent,
	input  logic [CW-1:0]    vm_rd_pre,
	input  logic [CW-1:0]    vm_rd_inl,
	input  logic [CW-1:0]    vm_rd_asc,
	output vm_we_t           vm_we,
	output logic [AW-1:0]    vm_waddr,
	output logic [VTX_W-1:0] vm_wd_parent,
	output logic [CW-1:0]    vm_wd_pre,
	output logic [CW-1:0]    vm_wd_inl,
	output logic [CW-1:0]    vm_wd_asc
);

	localparam int QW = (CW > VTX_W) ? CW : VTX_W;
	localparam logic [AW-1:0] WRAP_SLOT = AW'(64'hFFFF_FFFF % 64'(MAX_NODES));

	typedef enum logic [22:0] {
		S_IDLE    = 23'd1 << 0,
		S_COPY    = 23'd1 << 1,
		S_UP_A    = 23'd1 << 2,
		S_UP_V    = 23'd1 << 3,
		S_UP_P    = 23'd1 << 4,
		S_UP_W    = 23'd1 << 5,
		S_DN_R0   = 23'd1 << 6,
		S_DN_ROOT = 23'd1 << 7,
		S_DN_A    = 23'd1 << 8,
		S_DN_V    = 23'd1 << 9,
		S_DN_P    = 23'd1 << 10,
		S_DN_H    = 23'd1 << 11,
		S_DN_W    = 23'd1 << 12,
		S_Q_RV    = 23'd1 << 13,
		S_Q_RU    = 23'd1 << 14,
		S_Q_LAB   = 23'd1 << 15,
		S_Q_J     = 23'd1 << 16,
		S_Q_CV    = 23'd1 << 17,
		S_Q_CU    = 23'd1 << 18,
		S_Q_PX    = 23'd1 << 19,
		S_Q_PY    = 23'd1 << 20,
		S_Q_CMP   = 23'd1 << 21,
		S_RESP    = 23'd1 << 22
	} state_t;

	function automatic logic [AW-1:0] slot_vtx(input logic [VTX_W-1:0] x);
		logic [VTX_W-1:0] r;
		r = x;
		if (MAX_NODES < (1 << VTX_W)) begin
			for (int k = VTX_W - 1; k >= 0; k--) begin
				if ((MAX_NODES << k) < (1 << VTX_W) && int'(r) >= (MAX_NODES << k)) begin
					r = r - VTX_W'(MAX_NODES << k);
				end
			end
		end
		return AW'(r);
	endfunction

	function automatic logic [AW-1:0] slot_dec(input logic [CW-1:0] x);
		logic [CW-1:0] d;
		d = x - CW'(1);
		if (d >= CW'(MAX_NODES)) begin
			d = d - CW'(MAX_NODES);
		end
		return (x == '0) ? WRAP_SLOT : AW'(d);
	endfunction

	function automatic logic [CW-1:0] low_set(input logic [CW-1:0] x);
		return x & (~x + CW'(1));
	endfunction

	function automatic logic [CW-1:0] high_set(input logic [CW-1:0] x);
		logic [CW-1:0] r;
		r = '0;
		for (int k = 0; k < CW; k++) begin
			if (x[k]) begin
				r = CW'(1) << k;
			end
		end
		return r;
	endfunction

	function automatic logic [AW-1:0] climb_idx(input logic [CW-1:0] asc,
			input logic [CW-1:0] pre, input logic [CW-1:0] j);
		logic [CW-1:0] m;
		m = high_set(asc & (j - CW'(1))) - CW'(1);
		return slot_dec((pre & ~m) | (m + CW'(1)));
	endfunction

	state_t           state_q;
	logic             tree_ready_q;
	logic [CW-1:0]    node_count_q;
	logic [CW-1:0]    i_q;
	logic             cp_v_s1;
	logic [AW-1:0]    cp_a_s1;

	logic [VTX_W-1:0] u_q, v_q, par_q, x_q, y_q;
	logic [AW-1:0]    vs_q, ps_q, hidx_q;
	logic [CW-1:0]    lab_v_q, pre_v_q, asc_v_q;
	logic [CW-1:0]    lab_u_q, pre_u_q, asc_u_q;
	logic [CW-1:0]    j_q, hv_q, hu_q, pre_x_q;
	logic             cond_q, dir_v_q, dir_u_q;
	rsp_t             res_q;

	logic             accept;
	logic [CW-1:0]    nc_eff;
	logic             room;
	logic             q_err;
	logic [QW-1:0]    ext_a, ext_b, ext_n;
	logic [AW-1:0]    slot_a, vs_rd, ps_rd;
	logic [CW-1:0]    i_dec, i_inc;
	logic [CW-1:0]    hv_c, hu_c, mm_c, j_c;
	logic [VTX_W-1:0] head_val;

	assign accept  = req_valid && !req_stall;
	assign nc_eff  = tree_ready_q ? '0 : node_count_q;
	assign room    = nc_eff < CW'(MAX_NODES);
	assign ext_a   = QW'(req.vertex_a);
	assign ext_b   = QW'(req.vertex_b);
	assign ext_n   = QW'(node_count_q);
	assign q_err   = !tree_ready_q || ext_a >= ext_n || ext_b >= ext_n;
	assign slot_a  = slot_vtx(req.vertex_a);
	assign vs_rd   = slot_vtx(pm_rd_order);
	assign ps_rd   = slot_vtx(vm_rd_parent);
	assign i_dec   = i_q - CW'(1);
	assign i_inc   = i_q + CW'(1);
	assign hv_c    = low_set(lab_v_q);
	assign hu_c    = low_set(lab_u_q);
	assign mm_c    = high_set((lab_v_q ^ lab_u_q) | hv_c | hu_c) - CW'(1);
	assign j_c     = low_set(asc_v_q & asc_u_q & ~mm_c);
	assign head_val = cond_q ? par_q : pm_rd_head;

	assign req_stall    = (state_q != S_IDLE);
	assign st.idle      = (state_q == S_IDLE);
	assign st.res_valid = (state_q == S_RESP);
	assign res          = res_q;

	always_comb begin
		pm_raddr     = '0;
		pm_we        = '0;
		pm_waddr     = '0;
		pm_wdata     = req.vertex_a;
		vm_raddr     = '0;
		vm_we        = '0;
		vm_waddr     = '0;
		vm_wd_parent = req.vertex_b;
		vm_wd_pre    = nc_eff + CW'(1);
		vm_wd_inl    = vm_rd_pre;
		vm_wd_asc    = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && req.command == CMD_LOAD && room) begin
					pm_we.order  = 1'b1;
					pm_waddr     = nc_eff[AW-1:0];
					vm_we.parent = 1'b1;
					vm_we.pre    = 1'b1;
					vm_waddr     = slot_a;
				end
			end
			S_COPY: begin
				vm_raddr  = i_q[AW-1:0];
				vm_we.inl = cp_v_s1;
				vm_waddr  = cp_a_s1;
			end
			S_UP_A: pm_raddr = i_dec[AW-1:0];
			S_UP_V: vm_raddr = vs_rd;
			S_UP_P: vm_raddr = ps_rd;
			S_UP_W: begin
				vm_we.inl = low_set(vm_rd_inl) < low_set(lab_v_q);
				vm_waddr  = ps_q;
				vm_wd_inl = lab_v_q;
			end
			S_DN_R0: pm_raddr = '0;
			S_DN_ROOT: begin
				pm_we.head = 1'b1;
				pm_waddr   = '0;
				pm_wdata   = pm_rd_order;
				vm_we.asc  = 1'b1;
				vm_waddr   = vs_rd;
				vm_wd_asc  = '0;
			end
			S_DN_A: pm_raddr = i_q[AW-1:0];
			S_DN_V: vm_raddr = vs_rd;
			S_DN_P: vm_raddr = ps_rd;
			S_DN_H: begin
				vm_we.asc = 1'b1;
				vm_waddr  = vs_q;
				vm_wd_asc = vm_rd_asc | low_set(lab_v_q);
				pm_raddr  = slot_dec(vm_rd_pre);
			end
			S_DN_W: begin
				pm_we.head = 1'b1;
				pm_waddr   = hidx_q;
				pm_wdata   = head_val;
			end
			S_Q_RV: vm_raddr = slot_vtx(v_q);
			S_Q_RU: vm_raddr = slot_vtx(u_q);
			S_Q_CV: pm_raddr = climb_idx(asc_v_q, pre_v_q, j_q);
			S_Q_CU: pm_raddr = climb_idx(asc_u_q, pre_u_q, j_q);
			S_Q_PX: vm_raddr = slot_vtx(x_q);
			S_Q_PY: vm_raddr = slot_vtx(y_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			tree_ready_q <= 1'b0;
			node_count_q <= '0;
			i_q          <= '0;
			cp_v_s1      <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.command == CMD_LOAD) begin
							tree_ready_q <= 1'b0;
							node_count_q <= nc_eff + CW'(room);
							i_q          <= '0;
							cp_v_s1      <= 1'b0;
							if (req.last_entry) begin
								state_q <= S_COPY;
							end
						end else if (q_err) begin
							state_q <= S_RESP;
						end else begin
							state_q <= S_Q_RV;
						end
					end
				end
				S_COPY: begin
					cp_v_s1 <= (i_q < node_count_q);
					if (i_q < node_count_q) begin
						i_q <= i_inc;
					end else if (!cp_v_s1) begin
						state_q <= (node_count_q > CW'(1)) ? S_UP_A : S_DN_R0;
					end
				end
				S_UP_A: state_q <= S_UP_V;
				S_UP_V: state_q <= S_UP_P;
				S_UP_P: state_q <= S_UP_W;
				S_UP_W: begin
					i_q     <= i_dec;
					state_q <= (i_q > CW'(2)) ? S_UP_A : S_DN_R0;
				end
				S_DN_R0: state_q <= S_DN_ROOT;
				S_DN_ROOT: begin
					i_q <= CW'(1);
					if (node_count_q > CW'(1)) begin
						state_q <= S_DN_A;
					end else begin
						tree_ready_q <= 1'b1;
						state_q      <= S_RESP;
					end
				end
				S_DN_A: state_q <= S_DN_V;
				S_DN_V: state_q <= S_DN_P;
				S_DN_P: state_q <= S_DN_H;
				S_DN_H: state_q <= S_DN_W;
				S_DN_W: begin
					i_q <= i_inc;
					if (i_inc < node_count_q) begin
						state_q <= S_DN_A;
					end else begin
						tree_ready_q <= 1'b1;
						state_q      <= S_RESP;
					end
				end
				S_Q_RV:  state_q <= S_Q_RU;
				S_Q_RU:  state_q <= S_Q_LAB;
				S_Q_LAB: state_q <= S_Q_J;
				S_Q_J:   state_q <= S_Q_CV;
				S_Q_CV:  state_q <= S_Q_CU;
				S_Q_CU:  state_q <= S_Q_PX;
				S_Q_PX:  state_q <= S_Q_PY;
				S_Q_PY:  state_q <= S_Q_CMP;
				S_Q_CMP: state_q <= S_RESP;
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				u_q <= req.vertex_a;
				v_q <= req.vertex_b;
				if (req.command == CMD_LOAD) begin
					res_q <= '{response_kind: RSP_BUILD, ancestor: '0, error: 1'b0};
				end else begin
					res_q <= '{response_kind: RSP_ANSWER, ancestor: '0, error: 1'b1};
				end
			end
			S_COPY: cp_a_s1 <= i_q[AW-1:0];
			S_UP_V: vs_q <= vs_rd;
			S_UP_P: begin
				lab_v_q <= vm_rd_inl;
				ps_q    <= ps_rd;
			end
			S_DN_V: vs_q <= vs_rd;
			S_DN_P: begin
				par_q   <= vm_rd_parent;
				lab_v_q <= vm_rd_inl;
				pre_v_q <= vm_rd_pre;
			end
			S_DN_H: begin
				cond_q <= (lab_v_q != vm_rd_inl);
				hidx_q <= slot_dec(pre_v_q);
			end
			S_Q_RU: begin
				lab_v_q <= vm_rd_inl;
				pre_v_q <= vm_rd_pre;
				asc_v_q <= vm_rd_asc;
			end
			S_Q_LAB: begin
				lab_u_q <= vm_rd_inl;
				pre_u_q <= vm_rd_pre;
				asc_u_q <= vm_rd_asc;
			end
			S_Q_J: begin
				j_q  <= j_c;
				hv_q <= hv_c;
				hu_q <= hu_c;
			end
			S_Q_CV: dir_v_q <= (j_q == hv_q);
			S_Q_CU: begin
				x_q     <= dir_v_q ? v_q : pm_rd_head;
				dir_u_q <= (j_q == hu_q);
			end
			S_Q_PX: y_q <= dir_u_q ? u_q : pm_rd_head;
			S_Q_PY: pre_x_q <= vm_rd_pre;
			S_Q_CMP: begin
				res_q.error    <= 1'b0;
				res_q.ancestor <= (pre_x_q < vm_rd_pre) ? x_q : y_q;
			end
			default: ;
		endcase
	end

endmodule
